FILE: rtl/rtv_pkg.sv
package rtv_pkg;

  // String length limits for the two rule sets.
  localparam int NAME_LEN = 8;
  localparam int TEXT_LEN = 64;

  // A character is judged with three bytes behind it and four ahead of it.
  localparam int LOOK_BACK  = 3;
  localparam int LOOK_AHEAD = 4;
  localparam int SPAN       = LOOK_BACK + 1 + LOOK_AHEAD;
  localparam int CELLS      = LOOK_BACK + LOOK_AHEAD;
  localparam int JUDGES     = LOOK_AHEAD + 1;

  localparam int MAX_LEN = (TEXT_LEN > NAME_LEN) ? TEXT_LEN : NAME_LEN;
  localparam int RCV_MAX = MAX_LEN + JUDGES;
  localparam int RCV_W   = $clog2(RCV_MAX + 1);

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_SP  = 8'h20;
  localparam logic [7:0] BYTE_TOP = 8'h7E;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic MODE_NAME = 1'b0;
  localparam logic MODE_TEXT = 1'b1;

  typedef logic [RCV_W-1:0] rcv_t;

  // A byte together with the classes the rules look at.
  typedef struct packed {
    logic [7:0] code;
    logic       upper;
    logic       lower;
    logic       alpha;
    logic       digit;
    logic       space;
    logic       zero;
    logic       cr;
    logic       fin;
    logic       mark;
    logic       dot;
    logic       p_sn;
    logic       p_rt;
    logic       prnt;
    logic       lw;
    logic       lp;
    logic       ll;
    logic       ld;
    logic       le;
    logic       lf;
    logic       lm;
    logic       lc;
    logic       lo;
  } char_t;

  // Outcome of judging one character, split by where a failure falls
  // relative to the non-space count and the case-change count.
  typedef struct packed {
    logic ended;
    logic pre_fail;
    logic ns;
    logic mid_fail;
    logic cc;
    logic post_fail;
  } judge_t;

  function automatic char_t classify(input logic [7:0] b);
    char_t      r;
    logic [7:0] fold;
    fold    = b | CASE_BIT;
    r.code  = b;
    r.upper = (b >= "A") && (b <= "Z");
    r.lower = (b >= "a") && (b <= "z");
    r.alpha = r.upper || r.lower;
    r.digit = (b >= "0") && (b <= "9");
    r.space = (b == BYTE_SP);
    r.zero  = (b == BYTE_NUL);
    r.cr    = (b == BYTE_CR);
    r.fin   = r.zero || r.space || r.cr;
    r.mark  = !r.alpha && !r.digit && !r.space;
    r.dot   = (b == ".");
    r.p_sn  = (b == ".") || (b == ",");
    r.p_rt  = r.p_sn || (b == ":") || (b == ";") || (b == "!") || (b == "?");
    r.prnt  = (b >= BYTE_SP) && (b <= BYTE_TOP);
    r.lw    = r.alpha && (fold == "w");
    r.lp    = r.alpha && (fold == "p");
    r.ll    = r.alpha && (fold == "l");
    r.ld    = r.alpha && (fold == "d");
    r.le    = r.alpha && (fold == "e");
    r.lf    = r.alpha && (fold == "f");
    r.lm    = r.alpha && (fold == "m");
    r.lc    = r.alpha && (fold == "c");
    r.lo    = r.alpha && (fold == "o");
    return r;
  endfunction

endpackage

FILE: rtl/rtv_cell.sv
module rtv_cell import rtv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  logic  clear,
  input  char_t d,
  output char_t q
);

  char_t q_r;

  // One window slot: takes its neighbor's byte on every accepted request,
  // and empties when the string ends.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= classify(BYTE_NUL);
    end else if (shift_en) begin
      q_r <= clear ? classify(BYTE_NUL) : d;
    end
  end

  assign q = q_r;

endmodule

FILE: rtl/rtv_judge.sv
module rtv_judge import rtv_pkg::*; (
  input  logic   text_mode,
  input  logic   past_limit,
  input  char_t  win [SPAN],
  output judge_t res
);

  char_t lb3, lb2, p, c, n1, n2, n3, n4;
  logic  dom;
  logic  bad_pair;

  assign lb3 = win[LOOK_BACK-3];
  assign lb2 = win[LOOK_BACK-2];
  assign p   = win[LOOK_BACK-1];
  assign c   = win[LOOK_BACK];
  assign n1  = win[LOOK_BACK+1];
  assign n2  = win[LOOK_BACK+2];
  assign n3  = win[LOOK_BACK+3];
  assign n4  = win[LOOK_BACK+4];

  // A dot is part of a domain when "www" precedes it or a known suffix
  // follows it and then ends the word.
  assign dom = (lb3.lw && lb2.lw && p.lw) ||
               (n1.lp && n2.ll && n3.fin) ||
               (n1.ld && n2.le && n3.fin) ||
               (n1.lf && n2.lm && n3.fin) ||
               (n1.lc && n2.lo && n3.lm && n4.fin);

  assign bad_pair = p.alpha && n1.alpha && !(c.dot && dom);

  always_comb begin
    res.ended = past_limit || c.zero || ((text_mode == MODE_TEXT) && c.cr);
    res.ns    = !c.space;
    res.cc    = p.lower && c.upper;
    if (text_mode == MODE_NAME) begin
      res.pre_fail  = !(c.alpha || c.digit || c.space || c.p_sn);
      res.mid_fail  = (c.space && p.space) ||
                      (c.p_sn && (p.zero || p.space || bad_pair));
      res.post_fail = p.p_sn && (p.code == c.code);
    end else begin
      res.pre_fail  = !c.prnt;
      res.mid_fail  = (c.space && p.space) ||
                      (c.p_rt && !p.zero && (p.space || bad_pair)) ||
                      (((p.digit && c.alpha) || (p.alpha && c.digit)) && !n1.fin);
      res.post_fail = p.mark && c.mark && (p.code == c.code);
    end
  end

endmodule

FILE: rtl/rds_text_validator.sv
// Latency: the verdict for a string is registered at the edge that accepts its
//   last byte, on out_valid from the next cycle on if no older verdict waits.
// Throughput: one byte per cycle; input stalls only while two verdicts wait.
// Reset (rst_n low, synchronous): empty window, counters cleared, no verdict
//   pending, text_mode set to radio-text rules.
module rds_text_validator import rtv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_text_ok
);

  localparam logic [1:0] CNT_TWO = 2'd2;

  // Configuration and per-string scan state.
  logic       text_mode_r;
  rcv_t       rcv_r;
  logic       scan_r;
  logic       rej_r;
  logic [1:0] cc_r;
  logic [1:0] ns_r;

  // Result side: output register plus one skid slot.
  logic out_vld_r, out_ok_r;
  logic skid_vld_r, skid_ok_r;

  logic       acc;
  logic       out_take;
  logic [7:0] c_in;
  rcv_t       rcv_nxt;
  rcv_t       limit;
  char_t      char_nul;
  char_t      cell_q [CELLS];
  char_t      w [CELLS+1];
  judge_t     jr [JUDGES];
  logic [JUDGES-1:0] vld;
  logic [JUDGES-1:0] past;
  logic [JUDGES-1:0] act;
  logic       scan_nxt, rej_nxt;
  logic [1:0] cc_nxt, ns_nxt;
  logic       verdict;

  assign acc      = in_valid && !in_stall;
  assign out_take = out_vld_r && !out_stall;
  assign in_stall = skid_vld_r;
  assign out_valid   = out_vld_r;
  assign out_text_ok = out_ok_r;
  assign char_nul    = classify(BYTE_NUL);

  // Once a zero byte has arrived, every later byte of the string counts as
  // zero. Cell 0 holds the newest byte; it is zero after a clear as well, so
  // the count tells the two cases apart.
  assign c_in = ((rcv_r != '0) && cell_q[0].zero) ? BYTE_NUL : in_char_in;

  // The byte count saturates once every character is certainly past the
  // length limit, which keeps the limit compares correct for long strings.
  assign rcv_nxt = (rcv_r == rcv_t'(RCV_MAX)) ? rcv_r : rcv_r + rcv_t'(1);
  assign limit   = (text_mode_r == MODE_TEXT) ? rcv_t'(TEXT_LEN) : rcv_t'(NAME_LEN);

  // The window as it stands after the current request: w[0] is the
  // incoming byte, w[k] the byte received k requests before it.
  assign w[0] = classify(c_in);
  for (genvar k = 1; k <= CELLS; k++) begin : g_w
    assign w[k] = cell_q[k-1];
  end

  // The chain of cells shifts one slot per accepted request.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    rtv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (acc),
      .clear    (in_last),
      .d        (w[k]),
      .q        (cell_q[k])
    );
  end

  // A judge sits at each window slot that can hold a character due now.
  // Slot JUDGES-1 has its full lookahead and is judged on every byte; the
  // younger slots are judged only on the last byte, with zeros standing in
  // for the bytes that never came.
  for (genvar k = 0; k < JUDGES; k++) begin : g_judge
    char_t win [SPAN];
    for (genvar j = 0; j < SPAN; j++) begin : g_tap
      if (k + LOOK_BACK - j >= 0) begin : g_in
        assign win[j] = w[k+LOOK_BACK-j];
      end else begin : g_pad
        assign win[j] = char_nul;
      end
    end
    rtv_judge u_judge (
      .text_mode  (text_mode_r),
      .past_limit (past[k]),
      .win        (win),
      .res        (jr[k])
    );
  end

  // Slot k holds character number rcv_nxt-1-k. It exists when that number is
  // not negative and lies past the limit when it reaches the limit.
  always_comb begin
    for (int k = 0; k < JUDGES; k++) begin
      vld[k]  = rcv_nxt > rcv_t'(k);
      past[k] = {1'b0, rcv_nxt} > ({1'b0, limit} + (RCV_W+1)'(k));
      act[k]  = vld[k] && ((k == JUDGES - 1) || in_last);
    end
  end

  // Fold the judged characters into the scan state, oldest first. Any
  // failure ends the scan, so the counters only matter up to the first one.
  always_comb begin
    scan_nxt = scan_r;
    rej_nxt  = rej_r;
    cc_nxt   = cc_r;
    ns_nxt   = ns_r;
    for (int s = JUDGES - 1; s >= 0; s--) begin
      if (act[s] && !scan_nxt) begin
        if (jr[s].ended) begin
          scan_nxt = 1'b1;
        end else if (jr[s].pre_fail) begin
          scan_nxt = 1'b1;
          rej_nxt  = 1'b1;
        end else begin
          if (jr[s].ns && (ns_nxt != CNT_TWO)) begin
            ns_nxt = ns_nxt + 2'd1;
          end
          if (jr[s].mid_fail) begin
            scan_nxt = 1'b1;
            rej_nxt  = 1'b1;
          end else begin
            if (jr[s].cc && (cc_nxt != CNT_TWO)) begin
              cc_nxt = cc_nxt + 2'd1;
            end
            if ((jr[s].cc && (cc_nxt == CNT_TWO)) || jr[s].post_fail) begin
              scan_nxt = 1'b1;
              rej_nxt  = 1'b1;
            end
          end
        end
      end
    end
    verdict = !rej_nxt && (ns_nxt == CNT_TWO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_mode_r <= MODE_TEXT;
    end else if (cfg_wr_en) begin
      text_mode_r <= cfg_wr_data;
    end
  end

  // Scan state: cleared after the last byte so the next string starts fresh.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcv_r  <= '0;
      scan_r <= 1'b0;
      rej_r  <= 1'b0;
      cc_r   <= '0;
      ns_r   <= '0;
    end else if (acc) begin
      if (in_last) begin
        rcv_r  <= '0;
        scan_r <= 1'b0;
        rej_r  <= 1'b0;
        cc_r   <= '0;
        ns_r   <= '0;
      end else begin
        rcv_r  <= rcv_nxt;
        scan_r <= scan_nxt;
        rej_r  <= rej_nxt;
        cc_r   <= cc_nxt;
        ns_r   <= ns_nxt;
      end
    end
  end

  // Verdict delivery. A new verdict goes to the output register when it is
  // free or being emptied, otherwise to the skid slot; a full skid slot
  // stalls the input until the output register drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (acc && in_last) begin
      if (!out_vld_r || out_take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_ok_r <= skid_ok_r;
      end
    end else if (acc && in_last) begin
      if (!out_vld_r || out_take) begin
        out_ok_r <= verdict;
      end else begin
        skid_ok_r <= verdict;
      end
    end
  end

  // The skid slot is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid slot holds a verdict while the output register is empty");

  // A rejection always ends the scan.
  a_rej_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rej_r |-> scan_r)
    else $error("rejected string still being scanned");

  // The last byte of a string leaves the scan state clean for the next one.
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> ((rcv_r == '0) && !scan_r && !rej_r))
    else $error("scan state not cleared after the last byte");

  // Every accepted last byte leaves a verdict waiting at the output.
  a_verdict_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> out_vld_r)
    else $error("no verdict offered after the last byte");

endmodule

FILE: dv/rds_text_validator_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the RDS text validator. Strings are sent one byte per
// request; a local copy of the station-name and radio-text rules predicts the
// verdict of every string, and a checker process compares each verdict taken
// from the block against the oldest prediction.
module rds_text_validator_test import rtv_pkg::*; ();

  // Bytes past this count in one string are dropped by the rules.
  localparam int unsigned RX_CAP = 255;
  // Cycles of the long receiver hold-off used to back the block up.
  localparam int HOLD_LEN = 400;
  // Cycles without any accepted request before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in  = 8'h00;
  logic       in_last     = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic       out_text_ok;

  rds_text_validator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char_in  (in_char_in),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_text_ok (out_text_ok)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Verdict prediction. This mirrors the block's state: a window of the last
  // eight bytes, the index of the next character to judge, the count of bytes
  // taken in the current string and the running rule outcome.
  // ---------------------------------------------------------------------------
  logic [7:0]  text_win [0:7];
  int unsigned judge_pos;
  int unsigned bytes_taken;
  int unsigned nonspace_seen;
  int unsigned case_changes;
  bit          text_rejected;
  bit          scan_done;
  logic        rule_mode = MODE_TEXT;

  // Predicted verdicts, oldest first.
  logic        verdict_q [$];

  // A byte beyond what has arrived reads as zero, like the end of the text.
  function automatic logic [7:0] win_byte(int unsigned j);
    if (j >= bytes_taken) return BYTE_NUL;
    return text_win[j % 8];
  endfunction

  function automatic bit up_c(logic [7:0] c);
    return (c >= "A") && (c <= "Z");
  endfunction

  function automatic bit lo_c(logic [7:0] c);
    return (c >= "a") && (c <= "z");
  endfunction

  function automatic bit al_c(logic [7:0] c);
    return up_c(c) || lo_c(c);
  endfunction

  function automatic bit dg_c(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit word_end(logic [7:0] c);
    return (c == BYTE_NUL) || (c == BYTE_SP) || (c == BYTE_CR);
  endfunction

  function automatic bit name_punct(logic [7:0] c);
    return (c == ".") || (c == ",");
  endfunction

  function automatic bit text_punct(logic [7:0] c);
    return name_punct(c) || (c == ":") || (c == ";") || (c == "!") || (c == "?");
  endfunction

  function automatic bit mark_c(logic [7:0] c);
    return !al_c(c) && !dg_c(c) && (c != BYTE_SP);
  endfunction

  // Case-insensitive match against a lowercase letter.
  function automatic bit ci_eq(logic [7:0] c, logic [7:0] lower);
    return (c == lower) || (c == (lower ^ CASE_BIT));
  endfunction

  // A dot that belongs to a web address: "www." before it, or a short
  // country or generic suffix after it that closes the word.
  function automatic bit is_domain_dot(int unsigned i);
    logic [7:0] n1, n2, n3, n4;
    if (i >= 3 && ci_eq(win_byte(i - 3), "w") && ci_eq(win_byte(i - 2), "w") &&
        ci_eq(win_byte(i - 1), "w"))
      return 1'b1;
    n1 = win_byte(i + 1);
    n2 = win_byte(i + 2);
    n3 = win_byte(i + 3);
    n4 = win_byte(i + 4);
    return (ci_eq(n1, "p") && ci_eq(n2, "l") && word_end(n3)) ||
           (ci_eq(n1, "d") && ci_eq(n2, "e") && word_end(n3)) ||
           (ci_eq(n1, "f") && ci_eq(n2, "m") && word_end(n3)) ||
           (ci_eq(n1, "c") && ci_eq(n2, "o") && ci_eq(n3, "m") && word_end(n4));
  endfunction

  function automatic void reject_text();
    text_rejected = 1'b1;
    scan_done     = 1'b1;
  endfunction

  // A lowercase-to-uppercase step is allowed once per string.
  function automatic void count_case(logic [7:0] prev, logic [7:0] c);
    if (lo_c(prev) && up_c(c)) begin
      if (case_changes < 2) case_changes++;
      if (case_changes > 1) reject_text();
    end
  endfunction

  function automatic void judge_char(int unsigned i);
    logic [7:0]  c, prev, nxt;
    bit          rt;
    int unsigned limit;
    c     = win_byte(i);
    prev  = (i > 0) ? win_byte(i - 1) : BYTE_NUL;
    nxt   = win_byte(i + 1);
    rt    = (rule_mode == MODE_TEXT);
    limit = rt ? TEXT_LEN : NAME_LEN;
    if (scan_done) return;
    if (i >= limit || c == BYTE_NUL || (rt && c == BYTE_CR)) begin
      scan_done = 1'b1;
      return;
    end
    if (!rt) begin
      if (!al_c(c) && !dg_c(c) && c != BYTE_SP && !name_punct(c)) begin
        reject_text();
        return;
      end
      if (c != BYTE_SP) nonspace_seen++;
      if (c == BYTE_SP && prev == BYTE_SP) begin
        reject_text();
        return;
      end
      if (name_punct(c)) begin
        if (i == 0 || prev == BYTE_SP) begin
          reject_text();
          return;
        end
        if (al_c(prev) && al_c(nxt) && !(c == "." && is_domain_dot(i))) begin
          reject_text();
          return;
        end
      end
      if (prev != BYTE_NUL) begin
        count_case(prev, c);
        if (name_punct(prev) && prev == c) reject_text();
      end
      return;
    end
    if (c < BYTE_SP || c > BYTE_TOP) begin
      reject_text();
      return;
    end
    if (c != BYTE_SP) nonspace_seen++;
    if (c == BYTE_SP && prev == BYTE_SP) begin
      reject_text();
      return;
    end
    if (prev != BYTE_NUL && text_punct(c)) begin
      if (prev == BYTE_SP) begin
        reject_text();
        return;
      end
      if (al_c(prev) && al_c(nxt) && !(c == "." && is_domain_dot(i))) begin
        reject_text();
        return;
      end
    end
    if (prev != BYTE_NUL) begin
      if (((dg_c(prev) && al_c(c)) || (al_c(prev) && dg_c(c))) && !word_end(nxt)) begin
        reject_text();
        return;
      end
      count_case(prev, c);
      if (text_rejected) return;
      if (mark_c(prev) && mark_c(c) && prev == c) reject_text();
    end
  endfunction

  function automatic void clear_text();
    for (int k = 0; k < 8; k++) text_win[k] = BYTE_NUL;
    judge_pos     = 0;
    bytes_taken   = 0;
    nonspace_seen = 0;
    case_changes  = 0;
    text_rejected = 1'b0;
    scan_done     = 1'b0;
  endfunction

  // Take one accepted byte. Characters are judged once four bytes of
  // lookahead exist; the last byte flushes the rest and yields the verdict.
  function automatic void take_byte(logic [7:0] c, logic last);
    logic [7:0] b;
    b = c;
    if (bytes_taken < RX_CAP) begin
      // Everything after a zero byte counts as zero.
      if (bytes_taken > 0 && text_win[(bytes_taken - 1) % 8] == BYTE_NUL) b = BYTE_NUL;
      text_win[bytes_taken % 8] = b;
      bytes_taken++;
    end
    while (!scan_done && judge_pos + LOOK_AHEAD < bytes_taken) begin
      judge_char(judge_pos);
      judge_pos++;
    end
    if (last) begin
      while (!scan_done && judge_pos < bytes_taken) begin
        judge_char(judge_pos);
        judge_pos++;
      end
      verdict_q.push_back(!text_rejected && nonspace_seen >= 2);
      clear_text();
    end
  endfunction

  initial clear_text();

  // ---------------------------------------------------------------------------
  // Traffic shaping. The sender idles with probability idle_pct per cycle and
  // the receiver stalls with probability stall_pct. A long hold-off is asked
  // for by bumping hold_asked; the receiver process counts it down itself.
  // ---------------------------------------------------------------------------
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int          hold_left  = 0;
  int          fail_count = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  logic        want_ok;

  // Verdict checker and receiver stall generator. Outputs are sampled at the
  // rising edge, before this edge's updates, which is what the block saw.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("text_ok: expected no verdict, actual %0b", out_text_ok);
          fail_count++;
        end else begin
          want_ok = verdict_q.pop_front();
          if (out_text_ok !== want_ok) begin
            $error("text_ok: expected %0b, actual %0b", want_ok, out_text_ok);
            fail_count++;
          end
        end
      end
      if (hold_asked != hold_taken) begin
        hold_taken <= hold_asked;
        hold_left  <= HOLD_LEN;
        out_stall  <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: any accepted request on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rds_text_validator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  logic [7:0] text_buf [$];
  string      punct_set = ".,:;!?";

  // Offer one byte and wait until the block takes it. Valid is left high after
  // acceptance so that the next byte can follow in the very next cycle; it is
  // only lowered at the start of a gap or by the drain.
  task automatic send_byte(input logic [7:0] c, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid   <= 1'b1;
    in_char_in <= c;
    in_last    <= last;
    do @(posedge clk); while (in_stall);
    take_byte(c, last);
    items_sent++;
  endtask

  task automatic send_text();
    for (int k = 0; k < text_buf.size(); k++) send_byte(text_buf[k], k == text_buf.size() - 1);
  endtask

  // Stop offering and wait until every predicted verdict has been checked.
  // The verdict is the block's last piece of work on a string, so after it
  // the block is idle and ready for a register write.
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rule_mode    = m;
  endtask

  task automatic send_str(input string s);
    text_buf.delete();
    for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
    send_text();
  endtask

  function automatic logic [7:0] rand_lower();
    return 8'("a" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_upper();
    return 8'("A" + $urandom_range(25));
  endfunction

  // Append a string, flipping the case of its letters at random.
  task automatic push_cased(input string s);
    logic [7:0] b;
    for (int k = 0; k < s.len(); k++) begin
      b = s[k];
      if (al_c(b) && $urandom_range(1)) b = b ^ CASE_BIT;
      text_buf.push_back(b);
    end
  endtask

  task automatic push_word();
    int n;
    n = $urandom_range(2, 6);
    for (int k = 0; k < n; k++)
      text_buf.push_back((k == 0 && $urandom_range(1)) ? rand_upper() : rand_lower());
  endtask

  task automatic push_domain();
    case ($urandom_range(5))
      0:       push_cased("www.");
      1:       push_cased(".pl");
      2:       push_cased(".de");
      3:       push_cased(".fm");
      4:       push_cased(".com");
      default: push_cased(".net");
    endcase
  endtask

  // Build one string. Most are plausible broadcast text: words, numbers and
  // web addresses with single spaces, sometimes closed by CR or a zero byte
  // with junk after it. The rest is byte noise drawn from every class.
  task automatic make_text(input int want_len);
    int         target;
    logic [7:0] b;
    text_buf.delete();
    target = want_len;
    if (target == 0)
      target = ($urandom_range(19) == 0) ? $urandom_range(60, 72) :
               $urandom_range(1, (rule_mode == MODE_TEXT) ? 18 : 11);
    if ($urandom_range(99) < 70) begin
      while (text_buf.size() < target) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: push_word();
          6: for (int k = $urandom_range(1, 4); k > 0; k--)
               text_buf.push_back(8'("0" + $urandom_range(9)));
          7, 8: begin
            push_word();
            push_domain();
          end
          default: text_buf.push_back(punct_set[$urandom_range(5)]);
        endcase
        if (text_buf.size() < target) begin
          case ($urandom_range(9))
            0:       push_cased(", ");
            1:       push_cased(". ");
            2:       text_buf.push_back(punct_set[$urandom_range(5)]);
            default: text_buf.push_back(BYTE_SP);
          endcase
        end
      end
      if ($urandom_range(7) == 0) text_buf.push_back(BYTE_CR);
      if ($urandom_range(9) == 0) begin
        text_buf.push_back(BYTE_NUL);
        for (int k = $urandom_range(3); k > 0; k--) text_buf.push_back(8'($urandom_range(255)));
      end
    end else begin
      while (text_buf.size() < target) begin
        case ($urandom_range(9))
          0, 1, 2: b = rand_lower();
          3:       b = rand_upper();
          4:       b = BYTE_SP;
          5:       b = 8'("0" + $urandom_range(9));
          6:       b = punct_set[$urandom_range(5)];
          7:       b = 8'($urandom_range(126, 33));
          8:       b = 8'($urandom_range(255));
          default: b = $urandom_range(1) ? BYTE_CR : BYTE_NUL;
        endcase
        text_buf.push_back(b);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Radio-text rules straight out of reset: a clean pair, CR ending the text
  // early, a non-printable byte, a doubled mark at the top of the printable
  // range, and a zero byte that turns the rest of the string into zeros.
  task automatic test_text_rules();
    send_str("Ok");
    text_buf = '{"A", BYTE_CR};
    send_text();
    text_buf = '{8'hFF};
    send_text();
    send_str("~~");
    text_buf = '{"A", BYTE_NUL, "Z"};
    send_text();
    drain_verdicts();
  endtask

  // Station-name rules: a leading comma-class mark, a domain dot, two case
  // changes, and a string running past the name length so its tail is only
  // lookahead.
  task automatic test_name_rules();
    write_mode(MODE_NAME);
    send_str(".A");
    send_str("a.pl");
    send_str("aBcD");
    send_str("12345678X");
    drain_verdicts();
  endtask

  // One random phase: traffic shape and rule set, then strings until the
  // byte budget is spent.
  task automatic test_random(input int unsigned idle, input int unsigned stall,
                             input logic m, input int budget);
    int start;
    idle_pct  = idle;
    stall_pct = stall;
    write_mode(m);
    start = items_sent;
    while (items_sent - start < budget) begin
      make_text(0);
      send_text();
    end
    drain_verdicts();
  endtask

  // The receiver holds off for a long stretch while short strings keep
  // coming, so verdicts pile up and the block has to stall its input.
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    write_mode(MODE_TEXT);
    hold_asked++;
    for (int k = 0; k < 20; k++) begin
      make_text($urandom_range(1, 3));
      send_text();
    end
    drain_verdicts();
  endtask

  // A string that runs well past the text length limit and past the point
  // where the block's byte count stops growing.
  task automatic test_overlong();
    idle_pct  = 0;
    stall_pct = 28;
    make_text(80);
    send_text();
    drain_verdicts();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_text_rules();
    test_name_rules();
    test_random(0, 0, MODE_TEXT, 60);
    test_random(61, 0, MODE_NAME, 60);
    test_random(0, 61, MODE_TEXT, 60);
    test_random(28, 28, MODE_NAME, 60);
    test_backpressure();
    test_overlong();

    // Keep the clock running so the block can show any verdict nobody asked for.
    idle_pct  = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("rds_text_validator test passed");
    end else begin
      $display("rds_text_validator test failed");
    end
    $finish;
  end

endmodule
